// File: design/atma_pkg.sv
package atma_pkg;

   localparam int SAMPLE_BITS  = 12;
   localparam int CHANNELS_DEF = 32;
   localparam int CHANNEL_W    = 5;
   localparam int COUNT_W      = 8;
   localparam int CNT_W        = COUNT_W + 1;
   localparam int SUM_W        = SAMPLE_BITS + CNT_W;
   localparam int TRIM_W       = SAMPLE_BITS + 1;
   localparam int WINDOW_EXTRA = 2;
   localparam int DIV_STEPS    = SUM_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_WORDS    = 4;
   localparam int CSR_DATA_W   = 64;

   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE  = {SAMPLE_BITS{1'b1}};
   localparam logic [CSR_DATA_W-1:0]  COUNT_RESET = 64'h0A0A_0A0A_0A0A_0A0A;

   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_WORD_0 = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_WORD_1 = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_WORD_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_WORD_3 = 2'd3;

   typedef struct packed {
      logic [CHANNEL_W-1:0]   channel;
      logic [SAMPLE_BITS-1:0] sample;
      logic                   measure_enable;
   } req_payload_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0]   result_channel;
      logic [SAMPLE_BITS-1:0] average;
      logic                   average_updated;
   } rsp_payload_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] avg;
      logic [SUM_W-1:0]       sum;
      logic [CNT_W-1:0]       cnt;
      logic [SAMPLE_BITS-1:0] max;
      logic [SAMPLE_BITS-1:0] min;
   } entry_type;

   typedef struct packed {
      logic load;
      logic compute;
      logic div_load;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic complete;
      logic out_free;
   } status_type;

endpackage

// File: design/atma_ctrl.sv
module atma_ctrl
   import atma_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type sts,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOKUP = 3'd1;
   localparam logic [2:0] S_PREP   = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.compute = 1'b1;
            state_in    = S_PREP;
         end
         S_PREP: begin
            if (sts.complete) begin
               cmd.div_load = 1'b1;
               div_cnt_in   = '0;
               state_in     = S_DIV;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   a_accept_starts_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_LOOKUP))
      else $error("accepted transaction did not start a lookup");

   a_divide_only_on_complete: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> sts.complete)
      else $error("divider running without a completed window");

   a_finish_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && sts.out_free) |=> (state_ff == S_IDLE))
      else $error("finished transaction did not return to idle");

endmodule

// File: design/atma_datapath.sv
module atma_datapath
   import atma_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  req_payload_type        req_payload,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  cmd_type                cmd,
   output status_type             sts
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CHANNEL_W:0] CH_LIMIT = (CHANNEL_W + 1)'(CHANNELS);

   localparam entry_type ENTRY_RESET = '{
      avg: '0, sum: '0, cnt: '0, max: '0, min: FULL_SCALE
   };

   entry_type win_mem [CHANNELS];

   logic [CSR_DATA_W-1:0] cfg_ff [CSR_WORDS];
   logic [CHANNELS-1:0]   valid_ff;
   req_payload_type       in_ff;
   entry_type             rd_word_ff;
   logic                  rd_valid_ff;
   entry_type             upd_ff, upd_in;
   logic                  complete_ff, complete_in;
   logic [COUNT_W-1:0]    n_ff, n_in;
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [COUNT_W-1:0]    rem_ff, rem_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   entry_type             cur;
   entry_type             new_entry;
   logic                  in_range;
   logic [IDX_W-1:0]      idx;
   logic [IDX_W-1:0]      req_idx;
   logic [CSR_DATA_W-1:0] count_word;
   logic [COUNT_W-1:0]    count_byte;
   logic [CNT_W-1:0]      limit;
   logic [TRIM_W-1:0]     trim;
   logic [SUM_W-1:0]      trim_ext;
   logic [CNT_W-1:0]      shifted;
   logic                  quo_bit;
   logic [SAMPLE_BITS-1:0] sat_avg;

   assign in_range = ({1'b0, in_ff.channel} < CH_LIMIT);
   assign idx      = in_ff.channel[IDX_W-1:0];
   assign req_idx  = req_payload.channel[IDX_W-1:0];
   assign cur      = rd_valid_ff ? rd_word_ff : ENTRY_RESET;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < CSR_WORDS; w++) begin
            cfg_ff[w] <= COUNT_RESET;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COUNT_WORD_0: cfg_ff[0] <= csr_data;
            CSR_COUNT_WORD_1: cfg_ff[1] <= csr_data;
            CSR_COUNT_WORD_2: cfg_ff[2] <= csr_data;
            CSR_COUNT_WORD_3: cfg_ff[3] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff       <= req_payload;
         rd_word_ff  <= win_mem[req_idx];
         rd_valid_ff <= valid_ff[req_idx];
      end
      if (cmd.finish && in_range) begin
         win_mem[idx] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.finish && in_range) begin
         valid_ff[idx] <= 1'b1;
      end
   end

   always_comb begin
      count_word  = cfg_ff[in_ff.channel[CHANNEL_W-1:3]];
      count_byte  = count_word[in_ff.channel[2:0] * COUNT_W +: COUNT_W];
      n_in        = n_ff;
      upd_in      = upd_ff;
      complete_in = complete_ff;
      limit       = '0;
      if (cmd.compute) begin
         n_in       = (count_byte == '0) ? COUNT_W'(1) : count_byte;
         limit      = {1'b0, n_in} + CNT_W'(WINDOW_EXTRA);
         upd_in     = cur;
         upd_in.max = (in_ff.sample > cur.max) ? in_ff.sample : cur.max;
         upd_in.min = (in_ff.sample < cur.min) ? in_ff.sample : cur.min;
         upd_in.sum = cur.sum + SUM_W'(in_ff.sample);
         upd_in.cnt = cur.cnt + 1'b1;
         complete_in = in_ff.measure_enable && in_range && (upd_in.cnt >= limit);
      end
   end

   always_comb begin
      trim     = {1'b0, upd_ff.max} + {1'b0, upd_ff.min};
      trim_ext = SUM_W'(trim);
      shifted  = {rem_ff, quo_ff[SUM_W-1]};
      quo_bit  = (shifted >= {1'b0, n_ff});
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (cmd.div_load) begin
         quo_in = (upd_ff.sum >= trim_ext) ? (upd_ff.sum - trim_ext) : '0;
         rem_in = '0;
      end else if (cmd.div_step) begin
         rem_in = quo_bit ? COUNT_W'(shifted - {1'b0, n_ff}) : shifted[COUNT_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], quo_bit};
      end
   end

   always_comb begin
      sat_avg   = (quo_ff > SUM_W'(FULL_SCALE)) ? FULL_SCALE : quo_ff[SAMPLE_BITS-1:0];
      new_entry = upd_ff;
      if (complete_ff || !in_ff.measure_enable) begin
         new_entry = ENTRY_RESET;
      end
      new_entry.avg = complete_ff ? sat_avg : cur.avg;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (cmd.finish) begin
         rsp_valid_in                   = 1'b1;
         rsp_payload_in.result_channel  = in_ff.channel;
         rsp_payload_in.average         = in_range ? new_entry.avg : '0;
         rsp_payload_in.average_updated = complete_ff;
      end
   end

   always_ff @(posedge clock) begin
      upd_ff         <= upd_in;
      n_ff           <= n_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         complete_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         complete_ff  <= complete_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.complete = complete_ff;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_payload_ff;

   a_finish_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over an untaken transaction");

   a_update_flag_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.average_updated) |->
         ({1'b0, rsp_payload.result_channel} < CH_LIMIT))
      else $error("update reported for a channel outside the range");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (n_ff != '0))
      else $error("divider started with a zero divisor");

endmodule

// File: design/adc_trimmed_mean_averager_top.sv
// An accepted transaction passes through the lookup, prep and finish states, and also through
// the divide state when the sample completes a window; finish waits until the result slot is free.
// No new transaction is taken until the result is loaded; the bit-serial restoring divider
// takes one quotient bit per cycle over the 21-bit trimmed sum.
// Reset is synchronous: counts return to 10, every channel reads as an empty window with
// average 0 at once, and no clearing pass is needed.
module adc_trimmed_mean_averager_top
   import atma_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type    cmd;
   status_type sts;

   assign csr_ready = 1'b1;

   atma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   atma_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// File: tb/adc_trimmed_mean_averager_top_tb.sv
`timescale 1ns / 1ps

module adc_trimmed_mean_averager_top_tb;
   import atma_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int LONG_WINDOW    = 32;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_COUNT_WORD_0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   req_payload_type sample_pending_q[$];
   rsp_payload_type avg_expected_q[$];

   logic [CSR_DATA_W-1:0]  count_word_copy [CSR_WORDS];
   logic [SUM_W-1:0]       win_sum [CHANNELS_DEF];
   logic [CNT_W-1:0]       win_cnt [CHANNELS_DEF];
   logic [SAMPLE_BITS-1:0] win_max [CHANNELS_DEF];
   logic [SAMPLE_BITS-1:0] win_min [CHANNELS_DEF];
   logic [SAMPLE_BITS-1:0] ch_avg  [CHANNELS_DEF];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int mismatch_count = 0;
   int idle_cycles    = 0;

   adc_trimmed_mean_averager_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_window(input logic [CHANNEL_W-1:0] ch);
      win_sum[ch] = '0;
      win_cnt[ch] = '0;
      win_max[ch] = '0;
      win_min[ch] = FULL_SCALE;
   endfunction

   function automatic logic [CNT_W-1:0] window_length(input logic [CHANNEL_W-1:0] ch);
      logic [COUNT_W-1:0] n;
      n = count_word_copy[ch[4:3]][ch[2:0]*COUNT_W +: COUNT_W];
      return (n == '0) ? CNT_W'(1) : CNT_W'(n);
   endfunction

   function automatic rsp_payload_type predict_average(input req_payload_type item);
      rsp_payload_type      res;
      logic [CHANNEL_W-1:0] ch;
      logic [CNT_W-1:0]     n;
      logic [TRIM_W-1:0]    trim;
      logic [SUM_W-1:0]     quot;
      ch = item.channel;
      n = window_length(ch);
      res.result_channel = ch;
      res.average_updated = 1'b0;
      if (item.measure_enable) begin
         if (item.sample > win_max[ch]) win_max[ch] = item.sample;
         if (item.sample < win_min[ch]) win_min[ch] = item.sample;
         win_sum[ch] = win_sum[ch] + item.sample;
         win_cnt[ch] = win_cnt[ch] + 1'b1;
         if (win_cnt[ch] >= n + WINDOW_EXTRA) begin
            trim = TRIM_W'(win_max[ch]) + TRIM_W'(win_min[ch]);
            quot = (win_sum[ch] >= trim) ? (win_sum[ch] - trim) / n : '0;
            ch_avg[ch] = (quot > FULL_SCALE) ? FULL_SCALE : quot[SAMPLE_BITS-1:0];
            clear_window(ch);
            res.average_updated = 1'b1;
         end
      end else begin
         clear_window(ch);
      end
      res.average = ch_avg[ch];
      return res;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] random_code();
      case ($urandom_range(0, 7))
         0: begin
            return '0;
         end
         1: begin
            return FULL_SCALE;
         end
         default: begin
            return SAMPLE_BITS'($urandom_range(0, 4095));
         end
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_counts(input int top);
      logic [CSR_DATA_W-1:0] v;
      v = '0;
      for (int b = 0; b < CSR_DATA_W / COUNT_W; b++) begin
         v[b*COUNT_W +: COUNT_W] = COUNT_W'($urandom_range(0, top));
      end
      return v;
   endfunction

   function automatic void queue_sample(input logic [CHANNEL_W-1:0] ch,
                                        input logic [SAMPLE_BITS-1:0] code,
                                        input logic en);
      req_payload_type item;
      item.channel = ch;
      item.sample = code;
      item.measure_enable = en;
      sample_pending_q.push_back(item);
   endfunction

   task automatic queue_random_traffic(input int budget);
      int               queued;
      int               len;
      int               mode;
      logic [CHANNEL_W-1:0] ch;
      logic [CNT_W-1:0] n;
      queued = 0;
      while (queued < budget) begin
         ch = CHANNEL_W'($urandom_range(0, CHANNELS_DEF - 1));
         n = window_length(ch);
         mode = $urandom_range(0, 9);
         if (mode < 7 && n <= LONG_WINDOW) begin
            if ($urandom_range(0, 1) == 1) begin
               queue_sample(ch, random_code(), 1'b0);
               queued++;
            end
            len = (mode == 6) ? $urandom_range(1, n + 1) : n + WINDOW_EXTRA;
            for (int i = 0; i < len; i++) begin
               queue_sample(ch, random_code(), 1'b1);
            end
            queued += len;
            if (mode == 6) begin
               queue_sample(ch, random_code(), 1'b0);
               queued++;
            end
         end else begin
            queue_sample(ch, random_code(), 1'($urandom_range(0, 1)));
            queued++;
         end
      end
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      while (sample_pending_q.size() != 0 || req_valid || avg_expected_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_count_word(input logic [CSR_INDEX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      count_word_copy[idx] = val;
   endtask

   task automatic write_all_counts(input logic [CSR_DATA_W-1:0] w0,
                                   input logic [CSR_DATA_W-1:0] w1,
                                   input logic [CSR_DATA_W-1:0] w2,
                                   input logic [CSR_DATA_W-1:0] w3);
      write_count_word(CSR_COUNT_WORD_0, w0);
      write_count_word(CSR_COUNT_WORD_1, w1);
      write_count_word(CSR_COUNT_WORD_2, w2);
      write_count_word(CSR_COUNT_WORD_3, w3);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            avg_expected_q.push_back(predict_average(req_payload));
         end
         if (!req_valid || !req_stall) begin
            if (sample_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_payload <= sample_pending_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (avg_expected_q.size() == 0) begin
               $error("result_channel %0d: result with no transaction outstanding",
                      rsp_payload.result_channel);
               mismatch_count++;
            end else begin
               want = avg_expected_q.pop_front();
               if (rsp_payload.result_channel !== want.result_channel) begin
                  $error("result_channel: expected %0d, actual %0d",
                         want.result_channel, rsp_payload.result_channel);
                  mismatch_count++;
               end
               if (rsp_payload.average !== want.average) begin
                  $error("average: expected %0d, actual %0d",
                         want.average, rsp_payload.average);
                  mismatch_count++;
               end
               if (rsp_payload.average_updated !== want.average_updated) begin
                  $error("average_updated: expected %0d, actual %0d",
                         want.average_updated, rsp_payload.average_updated);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("adc_trimmed_mean_averager_top_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int w = 0; w < CSR_WORDS; w++) begin
         count_word_copy[w] = COUNT_RESET;
      end
      for (int c = 0; c < CHANNELS_DEF; c++) begin
         clear_window(CHANNEL_W'(c));
         ch_avg[c] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset counts of ten: extremes, clears, and one window of a zero then full-scale samples.
      @(negedge clock);
      queue_sample(5'd0, '0, 1'b1);
      queue_sample(5'd31, FULL_SCALE, 1'b1);
      queue_sample(5'd0, FULL_SCALE, 1'b0);
      queue_sample(5'd5, '0, 1'b1);
      for (int i = 0; i < 11; i++) begin
         queue_sample(5'd5, FULL_SCALE, 1'b1);
      end
      queue_sample(5'd31, '0, 1'b0);
      queue_random_traffic(250);
      queue_sample(5'd9, '0, 1'b0);
      for (int i = 0; i < 5; i++) begin
         queue_sample(5'd9, random_code(), 1'b1);
      end
      wait_until_drained();

      // Zero counts act as one; the part-filled window on channel 9 completes at once.
      write_all_counts('0, '0, '0, '0);
      send_idle_pct = 49;
      @(negedge clock);
      queue_sample(5'd9, random_code(), 1'b1);
      queue_random_traffic(250);
      wait_until_drained();

      // Counts of 255 give a window of 257 samples.
      write_all_counts('1, '1, '1, '1);
      send_idle_pct = 0;
      stall_pct = 49;
      @(negedge clock);
      queue_sample(5'd17, random_code(), 1'b0);
      for (int i = 0; i < 257; i++) begin
         queue_sample(5'd17, random_code(), 1'b1);
      end
      queue_random_traffic(60);
      wait_until_drained();

      write_all_counts(random_counts(7), random_counts(7), random_counts(7), random_counts(7));
      send_idle_pct = 10;
      stall_pct = 10;
      @(negedge clock);
      queue_random_traffic(250);
      wait_until_drained();

      write_all_counts(random_counts(15), random_counts(15), random_counts(15),
                       random_counts(15));
      send_idle_pct = 0;
      stall_pct = 0;
      @(negedge clock);
      queue_random_traffic(250);
      wait_until_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("adc_trimmed_mean_averager_top_tb: PASS");
      end else begin
         $display("adc_trimmed_mean_averager_top_tb: FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
design/atma_pkg.sv
design/atma_ctrl.sv
design/atma_datapath.sv
design/adc_trimmed_mean_averager_top.sv
tb/adc_trimmed_mean_averager_top_tb.sv
